FILE: src/range_add_range_max_tree_assert.svh
// assertion macros used by the port-level checker file
`ifndef RANGE_ADD_RANGE_MAX_TREE_ASSERT_SVH
`define RANGE_ADD_RANGE_MAX_TREE_ASSERT_SVH

// same-cycle implication
`define RARMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rarmt assertion failed");

// next-cycle implication
`define RARMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rarmt assertion failed");

`endif

FILE: src/rarmt_pkg.sv
// types, request codes and saturating arithmetic for the range add / range max tree
`timescale 1ns / 1ps
package rarmt_pkg;

  localparam int unsigned ValW = 48;

  typedef logic signed [ValW-1:0] val_t;

  localparam val_t ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam val_t ValMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_SET = 2'd0,
    REQ_ADD = 2'd1,
    REQ_MAX = 2'd2
  } req_type_e;

  typedef struct packed {
    val_t max_v;
    val_t pend;
  } node_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctrl_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VISIT,
    ST_COV,
    ST_PD_CHK,
    ST_G0,
    ST_G1,
    ST_PD_CLR,
    ST_POP,
    ST_PU1,
    ST_PU2
  } state_e;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [ValW:0] s;
    s = {a[ValW-1], a} + {b[ValW-1], b};
    if (s[ValW] != s[ValW-1]) begin
      return s[ValW] ? ValMin : ValMax;
    end
    return s[ValW-1:0];
  endfunction

  function automatic node_t give(input node_t n, input val_t amt);
    node_t r;
    r.max_v = sat_add(n.max_v, amt);
    r.pend  = sat_add(n.pend, amt);
    return r;
  endfunction

  function automatic val_t vmax(input val_t a, input val_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: src/rarmt_node_mem.sv
// node storage: one word per tree node holding its maximum and pending add
`timescale 1ns / 1ps
module rarmt_node_mem
  import rarmt_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  node_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output node_t         rdata_o
);

  node_t mem_q [DEPTH];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rarmt_ctrl.sv
// tree walker: clearing pass, explicit recursion stack, push-down and pull-up sequencing
`timescale 1ns / 1ps
module rarmt_ctrl
  import rarmt_pkg::*;
#(
  parameter int unsigned LEAVES = 1024,
  localparam int unsigned IW = $clog2(LEAVES + 1),
  localparam int unsigned NW = $clog2(4 * LEAVES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  req_type_e     kind_i,
  input  logic [IW-1:0] x_i,
  input  logic [IW-1:0] y_i,
  input  val_t          value_i,
  output ctrl_stat_t    stat_o,
  output val_t          acc_o,
  output logic          mem_we_o,
  output logic [NW-1:0] mem_waddr_o,
  output node_t         mem_wdata_o,
  output logic          mem_re_o,
  output logic [NW-1:0] mem_raddr_o,
  input  node_t         mem_rdata_i
);

  localparam int unsigned MD   = 4 * LEAVES;
  localparam int unsigned SD   = $clog2(LEAVES);
  localparam int unsigned SAW  = $clog2(SD + 1);
  localparam int unsigned SDEP = 2 ** SAW;

  state_e        state_q, state_d;
  logic [NW-1:0] clr_q, clr_d;
  req_type_e     kind_q, kind_d;
  logic [IW-1:0] x_q, x_d, y_q, y_d;
  val_t          val_q, val_d;
  logic [NW-1:0] node_q, node_d;
  logic [IW-1:0] l_q, l_d, r_q, r_d;
  logic [SAW-1:0] sp_q, sp_d;
  val_t          acc_q, acc_d;
  val_t          pend_q, pend_d;
  val_t          nmax_q, nmax_d;
  val_t          a_q, a_d;

  logic [NW-1:0] stk_node_q [SDEP];
  logic [IW-1:0] stk_l_q [SDEP];
  logic [IW-1:0] stk_r_q [SDEP];
  logic          stk_right_q [SDEP];

  logic           push, mark;
  logic [IW-1:0]  mid, top_mid;
  logic           disjoint, covered, sp_empty;
  logic [NW-1:0]  left_node, right_node;
  logic [SAW-1:0] top_idx;
  logic [NW-1:0]  top_node;
  logic [IW-1:0]  top_l, top_r;
  logic           top_right;

  assign mid        = l_q + ((r_q - l_q) >> 1);
  assign disjoint   = (r_q <= x_q) || (l_q >= y_q);
  assign covered    = (x_q <= l_q) && (r_q <= y_q);
  assign left_node  = {node_q[NW-2:0], 1'b0};
  assign right_node = {node_q[NW-2:0], 1'b1};
  assign sp_empty   = (sp_q == '0);
  assign top_idx    = sp_q - 1'b1;
  assign top_node   = stk_node_q[top_idx];
  assign top_l      = stk_l_q[top_idx];
  assign top_r      = stk_r_q[top_idx];
  assign top_right  = stk_right_q[top_idx];
  assign top_mid    = top_l + ((top_r - top_l) >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == NW'(MD - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (go_i) state_d = ST_VISIT;
      end
      ST_VISIT: begin
        if (disjoint) begin
          state_d = ST_POP;
        end else if (covered) begin
          state_d = (kind_q == REQ_SET) ? ST_POP : ST_COV;
        end else begin
          state_d = ST_PD_CHK;
        end
      end
      ST_COV:    state_d = ST_POP;
      ST_PD_CHK: state_d = (mem_rdata_i.pend == '0) ? ST_VISIT : ST_G0;
      ST_G0:     state_d = ST_G1;
      ST_G1:     state_d = ST_PD_CLR;
      ST_PD_CLR: state_d = ST_VISIT;
      ST_POP: begin
        if (sp_empty) begin
          state_d = ST_IDLE;
        end else if (!top_right) begin
          state_d = ST_VISIT;
        end else if (kind_q == REQ_MAX) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_PU1;
        end
      end
      ST_PU1:  state_d = ST_PU2;
      ST_PU2:  state_d = ST_POP;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory requests and status
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = node_q;
    stat_o.busy = (state_q != ST_IDLE);
    stat_o.done = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
      end
      ST_VISIT: begin
        if (!disjoint) begin
          if (covered && kind_q == REQ_SET) begin
            mem_we_o          = 1'b1;
            mem_wdata_o.max_v = val_q;
          end else begin
            mem_re_o = 1'b1;
          end
        end
      end
      ST_COV: begin
        if (kind_q == REQ_ADD) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = give(mem_rdata_i, val_q);
        end
      end
      ST_PD_CHK: begin
        if (mem_rdata_i.pend != '0) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = left_node;
        end
      end
      ST_G0: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = left_node;
        mem_wdata_o = give(mem_rdata_i, pend_q);
        mem_re_o    = 1'b1;
        mem_raddr_o = right_node;
      end
      ST_G1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = right_node;
        mem_wdata_o = give(mem_rdata_i, pend_q);
      end
      ST_PD_CLR: begin
        mem_we_o          = 1'b1;
        mem_wdata_o.max_v = nmax_q;
      end
      ST_POP: begin
        if (sp_empty) begin
          stat_o.done = (kind_q == REQ_MAX);
        end else if (top_right && kind_q != REQ_MAX) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = {top_node[NW-2:0], 1'b0};
        end
      end
      ST_PU1: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = right_node;
      end
      ST_PU2: begin
        // pending add of this node was cleared on the way down
        mem_we_o          = 1'b1;
        mem_wdata_o.max_v = vmax(a_q, mem_rdata_i.max_v);
      end
      default: ;
    endcase
  end

  // walker registers
  always_comb begin
    clr_d  = clr_q;
    kind_d = kind_q;
    x_d    = x_q;
    y_d    = y_q;
    val_d  = val_q;
    node_d = node_q;
    l_d    = l_q;
    r_d    = r_q;
    sp_d   = sp_q;
    acc_d  = acc_q;
    pend_d = pend_q;
    nmax_d = nmax_q;
    a_d    = a_q;
    push   = 1'b0;
    mark   = 1'b0;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + 1'b1;
      ST_IDLE: begin
        if (go_i) begin
          kind_d = kind_i;
          x_d    = x_i;
          y_d    = y_i;
          val_d  = value_i;
          node_d = NW'(1);
          l_d    = '0;
          r_d    = IW'(LEAVES);
          sp_d   = '0;
          acc_d  = ValMin;
        end
      end
      ST_COV: begin
        if (kind_q == REQ_MAX) acc_d = vmax(acc_q, mem_rdata_i.max_v);
      end
      ST_PD_CHK: begin
        nmax_d = mem_rdata_i.max_v;
        pend_d = mem_rdata_i.pend;
        push   = (mem_rdata_i.pend == '0);
      end
      ST_PD_CLR: push = 1'b1;
      ST_POP: begin
        if (!sp_empty) begin
          if (!top_right) begin
            mark   = 1'b1;
            node_d = {top_node[NW-2:0], 1'b1};
            l_d    = top_mid;
            r_d    = top_r;
          end else begin
            sp_d   = sp_q - 1'b1;
            node_d = top_node;
          end
        end
      end
      ST_PU1: a_d = mem_rdata_i.max_v;
      default: ;
    endcase
    // descend into the left child
    if (push) begin
      sp_d   = sp_q + 1'b1;
      node_d = left_node;
      r_d    = mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    val_q  <= val_d;
    node_q <= node_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    pend_q <= pend_d;
    nmax_q <= nmax_d;
    a_q    <= a_d;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_node_q[sp_q]  <= node_q;
      stk_l_q[sp_q]     <= l_q;
      stk_r_q[sp_q]     <= r_q;
      stk_right_q[sp_q] <= 1'b0;
    end
    if (mark) begin
      stk_right_q[top_idx] <= 1'b1;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: src/range_add_range_max_tree.sv
// top level: request decode, result register, walker and node memory
//
// Lazy segment tree over LEAVES signed 48-bit values with point set, range add
// and range max requests. A request is taken at a rising edge with start_i high
// and busy_o low; req_type_i, lo_index_i, hi_index_i and value_i are sampled
// there. Only a range max request gives a result: result_valid_o is high for
// exactly one cycle with max_value_o, and the receiver cannot stall it.
// An empty range, a set outside the tree or an unused request code finishes
// at once; an empty query shows 0 in the cycle after it is taken.
// Other requests walk the tree one node at a time through one node memory
// with a registered read port. Every visited node has a visit and a return
// step; a covered node on an add or max also has a COV step, a partly
// covered node a check of its pending add and, when it pushes one down,
// the G0, G1 and PD_CLR steps, and the pull-up on a set or add has the
// PU1 and PU2 steps. The result appears in the cycle after the walk ends,
// and busy_o falls with it. After reset busy_o stays high while all
// 4*LEAVES node words are cleared, one node per cycle.
`timescale 1ns / 1ps
module range_add_range_max_tree
  import rarmt_pkg::*;
#(
  parameter int unsigned LEAVES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [10:0] lo_index_i,
  input  logic [10:0] hi_index_i,
  input  val_t        value_i,
  output logic        result_valid_o,
  output val_t        max_value_o
);

  localparam int unsigned IW = $clog2(LEAVES + 1);
  localparam int unsigned NW = $clog2(4 * LEAVES);
  localparam int unsigned CW = (IW > 11) ? IW : 11;

  logic [CW-1:0] lo_ext, hi_ext, hi_c;
  logic          accept, go, empty_res;
  req_type_e     kind;
  logic [IW-1:0] x, y;
  ctrl_stat_t    stat;
  val_t          acc;
  logic          res_valid_q, res_valid_d;
  val_t          res_q, res_d;

  logic          mem_we, mem_re;
  logic [NW-1:0] mem_waddr, mem_raddr;
  node_t         mem_wdata, mem_rdata;

  assign accept = start_i && !stat.busy;
  assign kind   = req_type_e'(req_type_i);
  assign lo_ext = CW'(lo_index_i);
  assign hi_ext = CW'(hi_index_i);
  assign hi_c   = (hi_ext > CW'(LEAVES)) ? CW'(LEAVES) : hi_ext;

  always_comb begin
    go        = 1'b0;
    empty_res = 1'b0;
    x         = IW'(lo_ext);
    y         = IW'(hi_c);
    case (kind)
      REQ_SET: begin
        go = accept && (lo_ext < CW'(LEAVES));
        y  = IW'(lo_ext + 1'b1);
      end
      REQ_ADD: go = accept && (lo_ext < hi_c);
      REQ_MAX: begin
        go        = accept && (lo_ext < hi_c);
        empty_res = accept && (lo_ext >= hi_c);
      end
      default: ;
    endcase
  end

  assign res_valid_d = stat.done || empty_res;
  assign res_d       = stat.done ? acc : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  rarmt_ctrl #(
    .LEAVES(LEAVES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .kind_i     (kind),
    .x_i        (x),
    .y_i        (y),
    .value_i    (value_i),
    .stat_o     (stat),
    .acc_o      (acc),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  rarmt_node_mem #(
    .DEPTH(4 * LEAVES)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy_o         = stat.busy;
  assign result_valid_o = res_valid_q;
  assign max_value_o    = res_q;

endmodule

FILE: src/rarmt_checker.sv
// port-level checker for the range add / range max tree, bound to the top level
`timescale 1ns / 1ps
`include "range_add_range_max_tree_assert.svh"
module rarmt_checker
  import rarmt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  req_type_i,
  input logic [10:0] lo_index_i,
  input logic [10:0] hi_index_i,
  input logic        result_valid_o,
  input val_t        max_value_o
);

  logic take, write_take, empty_take;
  logic origin_q, origin_d;

  assign take       = start_i && !busy_o;
  assign write_take = take && (req_type_i != REQ_MAX);
  assign empty_take = take && (req_type_i == REQ_MAX) && (lo_index_i >= hi_index_i);
  assign origin_d   = busy_o || (take && (req_type_i == REQ_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= 1'b0;
    end else begin
      origin_q <= origin_d;
    end
  end

  // a result follows a walk or an empty query
  `RARMT_ASSERT_IMP(a_res_origin, clk_i, rst_ni, result_valid_o, origin_q)
  // set and add requests never answer
  `RARMT_ASSERT_NXT(a_no_res_write, clk_i, rst_ni, write_take, !result_valid_o)
  // empty query answers zero at once
  `RARMT_ASSERT_NXT(a_empty_zero, clk_i, rst_ni, empty_take, result_valid_o && max_value_o == '0)
  // walker is back to idle when its result shows
  `RARMT_ASSERT_IMP(a_res_idle, clk_i, rst_ni, result_valid_o, !busy_o)

endmodule

bind range_add_range_max_tree rarmt_checker u_rarmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .req_type_i    (req_type_i),
  .lo_index_i    (lo_index_i),
  .hi_index_i    (hi_index_i),
  .result_valid_o(result_valid_o),
  .max_value_o   (max_value_o)
);

FILE: sim/tb_top.sv
// self-checking testbench for the range add / range max tree
`timescale 1ns / 1ps
module tb_top;
  import rarmt_pkg::*;

  localparam int unsigned LEAVES = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WatchdogLimit = 20000;
  localparam int NumRandom = 1600;

  // mirror of the lazy tree, with a queue of pending query answers
  class tree_scoreboard;
    longint node_hi[4*LEAVES];
    longint node_lazy[4*LEAVES];
    longint answers[$];
    int errors;
    int queries;

    function longint clamp_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (s > longint'(ValMax)) return longint'(ValMax);
      if (s < longint'(ValMin)) return longint'(ValMin);
      return s;
    endfunction

    function void bump(int k, longint amt);
      node_hi[k] = clamp_sum(node_hi[k], amt);
      node_lazy[k] = clamp_sum(node_lazy[k], amt);
    endfunction

    function void push(int k);
      if (node_lazy[k] != 0) begin
        bump(2*k, node_lazy[k]);
        bump(2*k+1, node_lazy[k]);
        node_lazy[k] = 0;
      end
    endfunction

    function void refresh(int k);
      node_hi[k] = (node_hi[2*k] > node_hi[2*k+1]) ? node_hi[2*k] : node_hi[2*k+1];
    endfunction

    function void write_leaf(int k, int l, int r, int at, longint v);
      int m;
      if (l + 1 == r) begin
        node_hi[k] = v;
        node_lazy[k] = 0;
        return;
      end
      m = l + (r - l) / 2;
      push(k);
      if (at < m) write_leaf(2*k, l, m, at, v);
      else write_leaf(2*k+1, m, r, at, v);
      refresh(k);
    endfunction

    function void add_span(int k, int l, int r, int x, int y, longint v);
      int m;
      if (r <= x || l >= y) return;
      if (x <= l && r <= y) begin
        bump(k, v);
        return;
      end
      m = l + (r - l) / 2;
      push(k);
      add_span(2*k, l, m, x, y, v);
      add_span(2*k+1, m, r, x, y, v);
      refresh(k);
    endfunction

    function longint max_span(int k, int l, int r, int x, int y);
      int m;
      longint a, b;
      if (r <= x || l >= y) return -(longint'(1) << 62);
      if (x <= l && r <= y) return node_hi[k];
      m = l + (r - l) / 2;
      push(k);
      a = max_span(2*k, l, m, x, y);
      b = max_span(2*k+1, m, r, x, y);
      return (a > b) ? a : b;
    endfunction

    function void note_request(logic [1:0] kind, int lo, int hi, longint v);
      if (hi > LEAVES) hi = LEAVES;
      if (kind == REQ_SET) begin
        if (lo < LEAVES) write_leaf(1, 0, LEAVES, lo, v);
      end else if (kind == REQ_ADD) begin
        if (lo < hi) add_span(1, 0, LEAVES, lo, hi, v);
      end else if (kind == REQ_MAX) begin
        answers.push_back((lo < hi) ? max_span(1, 0, LEAVES, lo, hi) : 0);
      end
    endfunction

    function void check_result(val_t got);
      longint want;
      if (answers.size() == 0) begin
        $error("max_value: unexpected result %0d", got);
        errors++;
        return;
      end
      want = answers.pop_front();
      queries++;
      if (longint'(got) != want) begin
        $error("max_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, result_valid_o;
  logic [1:0] req_type_i;
  logic [10:0] lo_index_i, hi_index_i;
  val_t value_i, max_value_o;

  tree_scoreboard sb;
  int idle_cycles;
  int sent;
  bit allow_gaps;

  range_add_range_max_tree #(.LEAVES(LEAVES)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // results and watchdog are sampled at the falling edge, away from drive edges
  always @(negedge clk_i) begin
    if (result_valid_o) sb.check_result(max_value_o);
    if ((start_i && !busy_o) || result_valid_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] kind, logic [10:0] lo, logic [10:0] hi, val_t v);
    start_i <= 1'b1;
    req_type_i <= kind;
    lo_index_i <= lo;
    hi_index_i <= hi;
    value_i <= v;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    sb.note_request(kind, lo, hi, longint'(v));
    sent++;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0: return ValMax;
      1: return ValMin;
      2, 3: return val_t'({$urandom, $urandom});
      default: return val_t'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  initial begin
    logic [1:0] kind;
    logic [10:0] lo, hi;
    sb = new();
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_type_i = REQ_SET;
    lo_index_i = '0;
    hi_index_i = '0;
    value_i = '0;
    idle_cycles = 0;
    sent = 0;
    allow_gaps = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_req(REQ_MAX, 11'd0, 11'd1024, '0);
    send_req(REQ_SET, 11'd0, 11'd0, ValMax);
    send_req(REQ_SET, 11'd1023, 11'd0, ValMin);
    send_req(REQ_SET, 11'd1024, 11'd0, 48'sd77);
    send_req(REQ_SET, 11'd2047, 11'd2047, 48'sd5);
    send_req(REQ_MAX, 11'd0, 11'd2047, '0);
    send_req(REQ_ADD, 11'd0, 11'd1024, ValMax);
    send_req(REQ_ADD, 11'd0, 11'd1024, ValMax);
    send_req(REQ_MAX, 11'd1, 11'd1024, '0);
    send_req(REQ_ADD, 11'd0, 11'd2047, ValMin);
    send_req(REQ_ADD, 11'd0, 11'd2047, ValMin);
    send_req(REQ_ADD, 11'd0, 11'd2047, ValMin);
    send_req(REQ_MAX, 11'd0, 11'd1024, '0);
    send_req(REQ_MAX, 11'd500, 11'd501, '0);
    send_req(REQ_MAX, 11'd300, 11'd300, '0);
    send_req(REQ_MAX, 11'd900, 11'd10, '0);
    send_req(REQ_ADD, 11'd7, 11'd7, 48'sd9);
    send_req(REQ_UNUSED, 11'd0, 11'd1024, ValMax);
    send_req(REQ_SET, 11'd512, 11'd0, -48'sd3);
    send_req(REQ_ADD, 11'd100, 11'd700, 48'sd12345);
    send_req(REQ_MAX, 11'd0, 11'd1024, '0);
    send_req(REQ_MAX, 11'd1023, 11'd1024, '0);
    drain();

    // random traffic; gaps off for the final stretch
    for (int i = 0; i < NumRandom; i++) begin
      allow_gaps = (i < NumRandom - 200) && ($urandom_range(0, 7) != 0);
      if (i == NumRandom / 2) drain();
      kind = ($urandom_range(0, 40) == 0) ? REQ_UNUSED : 2'($urandom_range(0, 2));
      lo = ($urandom_range(0, 30) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1023));
      case ($urandom_range(0, 5))
        0: hi = 11'($urandom);
        1: hi = 11'd1024;
        2: hi = lo + 11'($urandom_range(1, 4));
        default: hi = 11'($urandom_range(0, 1024));
      endcase
      send_req(kind, lo, hi, pick_value());
    end
    drain();
    repeat (200) @(posedge clk_i);

    $display("sent %0d requests incl. saturation, empty ranges, out of range sets", sent);
    $display("and unused codes; checked %0d query results", sb.queries);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
